>>> design/erot_pkg.sv
// ----------------------------------------------------------------------------
// erot_pkg
// Types and codes shared by the Euler point rotator: beat payloads, the
// internal pipeline item, rotation sequence codes and register indexes.
// ----------------------------------------------------------------------------
package erot_pkg;

    localparam int CoordW = 32;
    localparam int CoefW  = 18;
    localparam int FuncW  = 3;
    localparam int AddrW  = 3;

    localparam logic [FuncW-1:0] FUNC_X   = 3'd0;
    localparam logic [FuncW-1:0] FUNC_Y   = 3'd1;
    localparam logic [FuncW-1:0] FUNC_Z   = 3'd2;
    localparam logic [FuncW-1:0] FUNC_ZX  = 3'd3;
    localparam logic [FuncW-1:0] FUNC_ZYX = 3'd4;

    localparam logic [AddrW-1:0] REG_COS_X = 3'd0;
    localparam logic [AddrW-1:0] REG_SIN_X = 3'd1;
    localparam logic [AddrW-1:0] REG_COS_Y = 3'd2;
    localparam logic [AddrW-1:0] REG_SIN_Y = 3'd3;
    localparam logic [AddrW-1:0] REG_COS_Z = 3'd4;
    localparam logic [AddrW-1:0] REG_SIN_Z = 3'd5;

    localparam logic signed [CoefW-1:0] COEF_ONE  = 18'sd65536;
    localparam logic signed [CoefW-1:0] COEF_ZERO = 18'sd0;

    typedef struct packed {
        logic [FuncW-1:0]         func;
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
        logic signed [CoordW-1:0] point_z;
        logic                     last_point;
    } erot_in_t;

    typedef struct packed {
        logic signed [CoordW-1:0] rot_x;
        logic signed [CoordW-1:0] rot_y;
        logic signed [CoordW-1:0] rot_z;
        logic                     clipped;
        logic                     last_out;
    } erot_out_t;

    typedef struct packed {
        logic [FuncW-1:0]         func;
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] z;
        logic                     last;
        logic                     clip;
    } erot_item_t;

endpackage

>>> design/euler_point_rotator.sv
// ----------------------------------------------------------------------------
// euler_point_rotator
// Rotates a Q16.16 point by Rz, then Ry, then Rx, each stage chosen by func,
// with per-product rounding and per-stage saturation.
//
//   channel  ports                     beat
//   input    s_valid/s_ready/s_data    func, point, last flag
//   output   m_valid/m_ready/m_data    rotated point, clip, last flag
//   config   cfg_we/cfg_addr/cfg_wdata cos/sin registers, Q1.16
//
// One point per cycle while m_ready does not stall; two stages per plane unit
// (the last register doubling as the output register). Reset is synchronous
// and loads the identity rotation. A stall on m_ready holds every stage; the
// whole pipeline advances whenever the output register is empty or taken.
// ----------------------------------------------------------------------------
module euler_point_rotator (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  erot_pkg::erot_in_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output erot_pkg::erot_out_t              m_data,
    input  logic                             cfg_we,
    input  logic [erot_pkg::AddrW-1:0]       cfg_addr,
    input  logic [erot_pkg::CoefW-1:0]       cfg_wdata
);
    import erot_pkg::*;

    logic signed [CoefW-1:0] cos_x_reg, sin_x_reg;
    logic signed [CoefW-1:0] cos_y_reg, sin_y_reg;
    logic signed [CoefW-1:0] cos_z_reg, sin_z_reg;

    logic       advance;
    erot_item_t item_in;
    logic       apply_z, apply_y, apply_x;

    logic                     z_valid, y_valid, x_valid;
    erot_item_t               z_item, y_item, x_item;
    erot_item_t               z_done, y_done, x_done;
    logic signed [CoordW-1:0] z_a, z_b, y_a, y_b, x_a, x_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_x_reg <= COEF_ONE;
            sin_x_reg <= COEF_ZERO;
            cos_y_reg <= COEF_ONE;
            sin_y_reg <= COEF_ZERO;
            cos_z_reg <= COEF_ONE;
            sin_z_reg <= COEF_ZERO;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_COS_X: cos_x_reg <= cfg_wdata;
                REG_SIN_X: sin_x_reg <= cfg_wdata;
                REG_COS_Y: cos_y_reg <= cfg_wdata;
                REG_SIN_Y: sin_y_reg <= cfg_wdata;
                REG_COS_Z: cos_z_reg <= cfg_wdata;
                REG_SIN_Z: sin_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    always_comb begin
        item_in.func = s_data.func;
        item_in.x    = s_data.point_x;
        item_in.y    = s_data.point_y;
        item_in.z    = s_data.point_z;
        item_in.last = s_data.last_point;
        item_in.clip = 1'b0;
    end

    assign apply_z = item_in.func inside {FUNC_Z, FUNC_ZX, FUNC_ZYX};

    erot_plane u_plane_z (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .in_valid (s_valid),
        .in_item  (item_in),
        .in_a     (item_in.x),
        .in_b     (item_in.y),
        .coef_c   (cos_z_reg),
        .coef_s   (sin_z_reg),
        .in_apply (apply_z),
        .out_valid(z_valid),
        .out_item (z_item),
        .out_a    (z_a),
        .out_b    (z_b)
    );

    always_comb begin
        z_done   = z_item;
        z_done.x = z_a;
        z_done.y = z_b;
    end

    assign apply_y = z_done.func inside {FUNC_Y, FUNC_ZYX};

    erot_plane u_plane_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .in_valid (z_valid),
        .in_item  (z_done),
        .in_a     (z_done.z),
        .in_b     (z_done.x),
        .coef_c   (cos_y_reg),
        .coef_s   (sin_y_reg),
        .in_apply (apply_y),
        .out_valid(y_valid),
        .out_item (y_item),
        .out_a    (y_a),
        .out_b    (y_b)
    );

    always_comb begin
        y_done   = y_item;
        y_done.z = y_a;
        y_done.x = y_b;
    end

    assign apply_x = y_done.func inside {FUNC_X, FUNC_ZX, FUNC_ZYX};

    erot_plane u_plane_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .in_valid (y_valid),
        .in_item  (y_done),
        .in_a     (y_done.y),
        .in_b     (y_done.z),
        .coef_c   (cos_x_reg),
        .coef_s   (sin_x_reg),
        .in_apply (apply_x),
        .out_valid(x_valid),
        .out_item (x_item),
        .out_a    (x_a),
        .out_b    (x_b)
    );

    always_comb begin
        x_done   = x_item;
        x_done.y = x_a;
        x_done.z = x_b;
    end

    assign m_valid = x_valid;

    always_comb begin
        m_data.rot_x    = x_done.x;
        m_data.rot_y    = x_done.y;
        m_data.rot_z    = x_done.z;
        m_data.clipped  = x_done.clip;
        m_data.last_out = x_done.last;
    end

endmodule

>>> design/erot_plane.sv
// ----------------------------------------------------------------------------
// erot_plane
// One plane rotation (a, b) -> (c*a - s*b, s*a + c*b) in two register
// stages: four products, then round to nearest, add and saturate.
// ----------------------------------------------------------------------------
module erot_plane (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  advance,
    input  logic                                  in_valid,
    input  erot_pkg::erot_item_t                  in_item,
    input  logic signed [erot_pkg::CoordW-1:0]    in_a,
    input  logic signed [erot_pkg::CoordW-1:0]    in_b,
    input  logic signed [erot_pkg::CoefW-1:0]     coef_c,
    input  logic signed [erot_pkg::CoefW-1:0]     coef_s,
    input  logic                                  in_apply,
    output logic                                  out_valid,
    output erot_pkg::erot_item_t                  out_item,
    output logic signed [erot_pkg::CoordW-1:0]    out_a,
    output logic signed [erot_pkg::CoordW-1:0]    out_b
);
    import erot_pkg::*;

    localparam int CW = CoefW + 1;
    localparam int PW = CW + CoordW;
    localparam int RW = PW - 16;
    localparam int SW = RW + 1;

    function automatic logic signed [RW-1:0] round_q(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p + PW'(32768);
        return t[PW-1:16];
    endfunction

    logic signed [CW-1:0] c_ext;
    logic signed [CW-1:0] s_ext;
    logic signed [CW-1:0] s_neg;
    logic signed [PW-1:0] p_ca;
    logic signed [PW-1:0] p_nsb;
    logic signed [PW-1:0] p_sa;
    logic signed [PW-1:0] p_cb;

    logic                 v1_reg;
    erot_item_t           item1_reg;
    logic signed [CoordW-1:0] a1_reg;
    logic signed [CoordW-1:0] b1_reg;
    logic                 apply1_reg;
    logic signed [PW-1:0] p_ca_reg;
    logic signed [PW-1:0] p_nsb_reg;
    logic signed [PW-1:0] p_sa_reg;
    logic signed [PW-1:0] p_cb_reg;

    logic signed [SW-1:0] sum_a;
    logic signed [SW-1:0] sum_b;
    logic                 clip_a;
    logic                 clip_b;
    logic signed [CoordW-1:0] sat_a;
    logic signed [CoordW-1:0] sat_b;

    logic                 v2_reg;
    erot_item_t           item2_reg;
    erot_item_t           item2_next;
    logic signed [CoordW-1:0] a2_reg;
    logic signed [CoordW-1:0] b2_reg;

    localparam logic signed [SW-1:0] SatMax = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] SatMin = SW'(-64'sd2147483648);

    assign c_ext = {coef_c[CoefW-1], coef_c};
    assign s_ext = {coef_s[CoefW-1], coef_s};
    assign s_neg = -s_ext;

    assign p_ca  = PW'(c_ext) * PW'(in_a);
    assign p_nsb = PW'(s_neg) * PW'(in_b);
    assign p_sa  = PW'(s_ext) * PW'(in_a);
    assign p_cb  = PW'(c_ext) * PW'(in_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            item1_reg  <= in_item;
            a1_reg     <= in_a;
            b1_reg     <= in_b;
            apply1_reg <= in_apply;
            p_ca_reg   <= p_ca;
            p_nsb_reg  <= p_nsb;
            p_sa_reg   <= p_sa;
            p_cb_reg   <= p_cb;
        end
    end

    always_comb begin
        sum_a  = SW'(round_q(p_ca_reg)) + SW'(round_q(p_nsb_reg));
        sum_b  = SW'(round_q(p_sa_reg)) + SW'(round_q(p_cb_reg));
        clip_a = (sum_a > SatMax) || (sum_a < SatMin);
        clip_b = (sum_b > SatMax) || (sum_b < SatMin);
        if (sum_a > SatMax) begin
            sat_a = SatMax[CoordW-1:0];
        end else if (sum_a < SatMin) begin
            sat_a = SatMin[CoordW-1:0];
        end else begin
            sat_a = sum_a[CoordW-1:0];
        end
        if (sum_b > SatMax) begin
            sat_b = SatMax[CoordW-1:0];
        end else if (sum_b < SatMin) begin
            sat_b = SatMin[CoordW-1:0];
        end else begin
            sat_b = sum_b[CoordW-1:0];
        end
        item2_next      = item1_reg;
        item2_next.clip = item1_reg.clip | (apply1_reg & (clip_a | clip_b));
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            item2_reg <= item2_next;
            if (apply1_reg) begin
                a2_reg <= sat_a;
                b2_reg <= sat_b;
            end else begin
                a2_reg <= a1_reg;
                b2_reg <= b1_reg;
            end
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item2_reg;
    assign out_a     = a2_reg;
    assign out_b     = b2_reg;

endmodule
